// ----- src/assert_macros.svh -----
// assertion helpers included by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define OCL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// checked at every edge, reset included
`define OCL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/ocl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocl_pkg
// Shared types, constants and saturating helpers of the log transform unit.
// ----------------------------------------------------------------------------
package ocl_pkg;

    localparam int DW        = 32;
    localparam int FRAC_BITS = 16;
    localparam int LOG_FRAC  = 24;

    localparam logic [63:0] E_Q60   = 64'h2B7E_1516_28AE_D2A6;
    localparam logic [30:0] E_RAW   = 31'((E_Q60 + (64'd1 << (59 - FRAC_BITS)))
                                          >> (60 - FRAC_BITS));
    localparam logic [30:0] ONE_RAW = 31'(1) << FRAC_BITS;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        FN_FIT   = 2'd0,
        FN_APPLY = 2'd1,
        FN_EMPTY = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_FITTED = 2'd1,
        ST_BASE_ONE   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_BASE      = 2'd0,
        REG_USER_OFF  = 2'd1,
        REG_AUTO_OFF  = 2'd2,
        REG_FLOOR     = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [30:0]          base_raw;
        logic signed [DW-1:0] user_offset;
        logic                 auto_en;
        logic [30:0]          floor_eff;
    } t_cfg;

    // work handed from front to back
    typedef struct packed {
        logic          is_log;
        logic [DW-1:0] value;
        logic          kind;
        t_status       status;
    } t_job;

    function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? SMIN : SMAX;
        end
        return s[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? SMIN : SMAX;
        end
        return s[DW-1:0];
    endfunction

endpackage

// ----- src/offset_clamped_log_transform_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// offset_clamped_log_transform_unit
// Q16.16 log transform of spectral samples with a fitted or fixed offset.
// ----------------------------------------------------------------------------
// The front takes one beat per cycle for ordinary fit samples; the last fit
// beat, an empty fit and an apply beat keep the front full until their work
// is queued. Apply work goes through a 4-entry queue to the back, which runs
// a log2 unit (5 normalize steps, then 24 squarings on one 32x32 multiplier).
// A natural log result is then scaled by ln 2; any other base also takes
// the log2 of the base and a 47-step bit-serial divider. Fit reports and
// not-fitted results pass the back without the log2 unit. Results wait
// in one output register while the back goes on with the next queued beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module offset_clamped_log_transform_unit import ocl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input beats
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           i_func,
    input  logic signed [DW-1:0] i_sample,
    input  logic                 i_is_last,
    // result beats
    output logic                 empty,
    input  logic                 pop,
    output logic signed [DW-1:0] o_value,
    output logic                 o_report_kind,
    output logic [1:0]           o_status,
    // register writes
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [DW-1:0]        i_cfg_data
);

    logic [30:0]          r_base_raw;
    logic signed [DW-1:0] r_user_offset;
    logic                 r_auto_en;
    logic [30:0]          r_floor;

    t_cfg    cfg;
    logic    q_push;
    logic    q_full;
    t_job    q_job;
    logic    q_pop;
    logic    q_empty;
    t_job    q_head;
    t_status back_status;

    // plain register file; the user must write it only while the unit is idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_raw    <= '0;
            r_user_offset <= '0;
            r_auto_en     <= 1'b0;
            r_floor       <= 31'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BASE:     r_base_raw    <= i_cfg_data[30:0];
                REG_USER_OFF: r_user_offset <= i_cfg_data;
                REG_AUTO_OFF: r_auto_en     <= i_cfg_data[0];
                REG_FLOOR:    r_floor       <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // a zero floor acts as the smallest positive value
    always_comb begin
        cfg.base_raw    = r_base_raw;
        cfg.user_offset = r_user_offset;
        cfg.auto_en     = r_auto_en;
        cfg.floor_eff   = (r_floor == '0) ? 31'd1 : r_floor;
    end

    ocl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_func   (i_func),
        .i_sample (i_sample),
        .i_is_last(i_is_last),
        .i_cfg    (cfg),
        .o_q_push (q_push),
        .o_q_job  (q_job),
        .i_q_full (q_full)
    );

    ocl_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_job  (q_job),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_head (q_head),
        .o_empty(q_empty)
    );

    ocl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_q_empty    (q_empty),
        .i_q_job      (q_head),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_value      (o_value),
        .o_report_kind(o_report_kind),
        .o_status     (back_status)
    );

    assign o_status = back_status;

    // front only pushes when the queue has room
    `OCL_ASSERT(a_q_no_overflow, i_clk, i_rst_n, !(q_push && q_full), "work queue overflow")
    // offset reports never carry an error status
    `OCL_ASSERT(a_rpt_ok, i_clk, i_rst_n, !empty && o_report_kind |-> back_status == ST_OK, "bad report")
    // a base-one result carries a zero value
    `OCL_ASSERT(a_one_zero, i_clk, i_rst_n, !empty && back_status == ST_BASE_ONE |-> o_value == '0, "base one")
    // nothing waits on the result side right after reset
    `OCL_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> empty, "result pending after reset")

endmodule

// ----- src/ocl_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocl_front
// Takes input beats, tracks the fit minimum, fixes the offset and queues work.
// ----------------------------------------------------------------------------
module ocl_front import ocl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [1:0]           i_func,
    input  logic signed [DW-1:0] i_sample,
    input  logic                 i_is_last,
    input  t_cfg                 i_cfg,
    output logic                 o_q_push,
    output t_job                 o_q_job,
    input  logic                 i_q_full
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIT_SUB,
        S_FIT_ADD,
        S_REPORT,
        S_APPLY
    } t_state;

    t_state               r_state;
    logic signed [DW-1:0] r_min;
    logic                 r_min_seen;
    logic                 r_fitted;
    logic signed [DW-1:0] r_active;
    logic signed [DW-1:0] r_off;
    logic signed [DW-1:0] r_diff;
    logic                 r_use_diff;
    logic signed [DW-1:0] r_sample;
    logic                 r_not_fit;

    logic signed [DW-1:0] fit_t;
    logic signed [DW-1:0] n_min;
    logic signed [DW-1:0] off_sel;
    logic signed [DW-1:0] v_sum;
    logic signed [DW-1:0] v_pos;
    logic signed [DW-1:0] floor_s;

    assign floor_s = $signed({1'b0, i_cfg.floor_eff});

    always_comb begin
        fit_t   = sat_add(i_sample, i_cfg.user_offset);
        n_min   = (!r_min_seen || (fit_t < r_min)) ? fit_t : r_min;
        off_sel = i_cfg.auto_en ? r_active : i_cfg.user_offset;
        v_sum   = sat_add(r_sample, off_sel);
        v_pos   = (v_sum > 0) ? v_sum : floor_s;
    end

    assign o_full   = (r_state != S_IDLE);
    assign o_q_push = ((r_state == S_REPORT) || (r_state == S_APPLY)) && !i_q_full;

    always_comb begin
        o_q_job = '0;
        case (r_state)
            S_REPORT: begin
                o_q_job.is_log = 1'b0;
                o_q_job.value  = r_off;
                o_q_job.kind   = 1'b1;
                o_q_job.status = ST_OK;
            end
            S_APPLY: begin
                if (r_not_fit) begin
                    o_q_job.is_log = 1'b0;
                    o_q_job.value  = '0;
                    o_q_job.status = ST_NOT_FITTED;
                end else begin
                    o_q_job.is_log = 1'b1;
                    o_q_job.value  = v_pos;
                    o_q_job.status = ST_OK;
                end
                o_q_job.kind = 1'b0;
            end
            default: o_q_job = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_min      <= '0;
            r_min_seen <= 1'b0;
            r_fitted   <= 1'b0;
            r_active   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_push) begin
                        case (i_func)
                            FN_FIT: begin
                                r_min      <= n_min;
                                r_min_seen <= !i_is_last;
                                if (i_is_last) begin
                                    r_state <= S_FIT_SUB;
                                end
                            end
                            FN_EMPTY: begin
                                r_min_seen <= 1'b0;
                                r_off      <= i_cfg.user_offset;
                                r_state    <= S_REPORT;
                            end
                            FN_APPLY: begin
                                r_sample  <= i_sample;
                                r_not_fit <= i_cfg.auto_en && !r_fitted;
                                r_state   <= S_APPLY;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FIT_SUB: begin
                    r_use_diff <= i_cfg.auto_en && (r_min <= 0);
                    r_diff     <= sat_sub(floor_s, r_min);
                    r_state    <= S_FIT_ADD;
                end
                S_FIT_ADD: begin
                    r_off   <= r_use_diff ? sat_add(i_cfg.user_offset, r_diff)
                                          : i_cfg.user_offset;
                    r_state <= S_REPORT;
                end
                S_REPORT: begin
                    if (!i_q_full) begin
                        r_active <= r_off;
                        r_fitted <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_APPLY: begin
                    if (!i_q_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- src/ocl_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocl_fifo
// Short work queue between the front and the back.
// ----------------------------------------------------------------------------
module ocl_fifo import ocl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty
);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- src/ocl_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocl_back
// Log2 by repeated squaring, ln scaling or base division, result register.
// ----------------------------------------------------------------------------
module ocl_back import ocl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_q_empty,
    input  t_job                 i_q_job,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic signed [DW-1:0] o_value,
    output logic                 o_report_kind,
    output t_status              o_status
);

    typedef enum logic [3:0] {
        B_IDLE,
        B_NORM,
        B_SQR,
        B_LN_MUL,
        B_LN_RND,
        B_DIV_INIT,
        B_DIV,
        B_DFIN,
        B_OUT
    } t_state;

    t_state               r_state;
    logic [31:0]          r_m;
    logic [4:0]           r_s;
    logic [2:0]           r_step;
    logic [4:0]           r_sq_cnt;
    logic [5:0]           r_div_cnt;
    logic [23:0]          r_frac;
    logic                 r_pass_base;
    logic [30:0]          r_v;
    logic signed [29:0]   r_lb;
    logic signed [29:0]   r_lv;
    logic                 r_neg;
    logic [60:0]          r_prod;
    logic [46:0]          r_num;
    logic [29:0]          r_den;
    logic [29:0]          r_rem;
    logic [46:0]          r_q;
    logic signed [DW-1:0] r_res;
    logic                 r_res_kind;
    t_status              r_res_status;
    logic                 r_ov;
    logic signed [DW-1:0] r_out_value;
    logic                 r_out_kind;
    t_status              r_out_status;

    logic        is_nat;
    logic        is_one;
    logic        out_free;
    logic [4:0]  norm_k;
    logic        norm_zero;
    logic [63:0] sq;
    logic        sq_ovf;
    logic [31:0] m_next;
    logic [23:0] frac_next;
    logic [5:0]  l_hi;
    logic signed [29:0] l_val;
    logic [29:0] abs_lv;
    logic [29:0] abs_lb;
    logic [60:0] ln_sum;
    logic [20:0] ln_mag;
    logic [30:0] rem_sh;
    logic        rem_ge;

    assign is_nat   = (i_cfg.base_raw == '0) || (i_cfg.base_raw == E_RAW);
    assign is_one   = (i_cfg.base_raw == ONE_RAW);
    assign out_free = !r_ov || i_pop;
    assign o_q_pop  = (r_state == B_IDLE) && !i_q_empty;

    always_comb begin
        norm_k    = 5'd16 >> r_step;
        norm_zero = ((r_m >> (6'd32 - {1'b0, norm_k})) == '0);
        sq        = r_m * r_m;
        sq_ovf    = sq[63];
        m_next    = sq_ovf ? sq[63:32] : sq[62:31];
        frac_next = {r_frac[22:0], sq_ovf};
        l_hi      = 6'd15 - {1'b0, r_s};
        l_val     = $signed({l_hi, frac_next});
        abs_lv    = r_lv[29] ? 30'(-r_lv) : r_lv;
        abs_lb    = r_lb[29] ? 30'(-r_lb) : r_lb;
        ln_sum    = r_prod + (61'd1 << 39);
        ln_mag    = ln_sum[60:40];
        rem_sh    = {r_rem, r_num[46]};
        rem_ge    = (rem_sh >= {1'b0, r_den});
    end

    assign o_empty       = !r_ov;
    assign o_value       = r_out_value;
    assign o_report_kind = r_out_kind;
    assign o_status      = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if ((r_state == B_OUT) && out_free) begin
                r_ov <= 1'b1;
            end else if (i_pop && r_ov) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_res_kind   <= i_q_job.kind;
                        r_v          <= i_q_job.value[30:0];
                        r_s          <= '0;
                        r_step       <= '0;
                        if (!i_q_job.is_log) begin
                            r_res        <= i_q_job.value;
                            r_res_status <= i_q_job.status;
                            r_state      <= B_OUT;
                        end else if (is_nat) begin
                            r_res_status <= i_q_job.status;
                            r_pass_base  <= 1'b0;
                            r_m          <= {1'b0, i_q_job.value[30:0]};
                            r_state      <= B_NORM;
                        end else if (is_one) begin
                            r_res        <= '0;
                            r_res_status <= ST_BASE_ONE;
                            r_state      <= B_OUT;
                        end else begin
                            r_res_status <= i_q_job.status;
                            r_pass_base  <= 1'b1;
                            r_m          <= {1'b0, i_cfg.base_raw};
                            r_state      <= B_NORM;
                        end
                    end
                end
                B_NORM: begin
                    if (norm_zero) begin
                        r_m <= r_m << norm_k;
                        r_s <= r_s + norm_k;
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd4) begin
                        r_sq_cnt <= '0;
                        r_frac   <= '0;
                        r_state  <= B_SQR;
                    end
                end
                B_SQR: begin
                    r_frac   <= frac_next;
                    r_sq_cnt <= r_sq_cnt + 1'b1;
                    if (r_sq_cnt == 5'(LOG_FRAC - 1)) begin
                        if (r_pass_base) begin
                            r_lb <= l_val;
                            if (l_val == '0) begin
                                r_res        <= '0;
                                r_res_status <= ST_BASE_ONE;
                                r_state      <= B_OUT;
                            end else begin
                                r_pass_base <= 1'b0;
                                r_m         <= {1'b0, r_v};
                                r_s         <= '0;
                                r_step      <= '0;
                                r_state     <= B_NORM;
                            end
                        end else begin
                            r_lv    <= l_val;
                            r_state <= is_nat ? B_LN_MUL : B_DIV_INIT;
                        end
                    end else begin
                        r_m <= m_next;
                    end
                end
                B_LN_MUL: begin
                    r_prod  <= abs_lv[28:0] * LN2_Q32;
                    r_neg   <= r_lv[29];
                    r_state <= B_LN_RND;
                end
                B_LN_RND: begin
                    r_res   <= r_neg ? -$signed({11'b0, ln_mag}) : $signed({11'b0, ln_mag});
                    r_state <= B_OUT;
                end
                B_DIV_INIT: begin
                    r_num     <= {1'b0, abs_lv[28:0], 16'b0, 1'b0} + {18'b0, abs_lb[28:0]};
                    r_den     <= {abs_lb[28:0], 1'b0};
                    r_rem     <= '0;
                    r_q       <= '0;
                    r_div_cnt <= '0;
                    r_neg     <= r_lv[29] != r_lb[29];
                    r_state   <= B_DIV;
                end
                B_DIV: begin
                    r_rem     <= rem_ge ? 30'(rem_sh - {1'b0, r_den}) : rem_sh[29:0];
                    r_q       <= {r_q[45:0], rem_ge};
                    r_num     <= r_num << 1;
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == 6'd46) begin
                        r_state <= B_DFIN;
                    end
                end
                B_DFIN: begin
                    if (r_neg) begin
                        r_res <= (r_q > 47'h0_8000_0000) ? SMIN : -$signed(r_q[31:0]);
                    end else begin
                        r_res <= (r_q > 47'h0_7FFF_FFFF) ? SMAX : $signed(r_q[31:0]);
                    end
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (out_free) begin
                        r_out_value  <= r_res;
                        r_out_kind   <= r_res_kind;
                        r_out_status <= r_res_status;
                        r_state      <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule
